FILE: hw/rtl/ceru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ceru_pkg
// Shared types and constants of the 6502 execute register unit.
// ----------------------------------------------------------------------------
package ceru_pkg;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
        OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
        OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
        OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
        OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEX = 6'd19,
        OP_DEY = 6'd20, OP_DEC = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
        OP_INX = 6'd24, OP_INY = 6'd25, OP_JMP = 6'd26, OP_JSR = 6'd27,
        OP_LDA = 6'd28, OP_LDX = 6'd29, OP_LDY = 6'd30, OP_LSR = 6'd31,
        OP_ORA = 6'd32, OP_PHA = 6'd33, OP_PHP = 6'd34, OP_PLA = 6'd35,
        OP_PLP = 6'd36, OP_ROL = 6'd37, OP_ROR = 6'd38, OP_RTS = 6'd39,
        OP_SBC = 6'd40, OP_SEC = 6'd41, OP_SED = 6'd42, OP_SEI = 6'd43,
        OP_STA = 6'd44, OP_STX = 6'd45, OP_STY = 6'd46, OP_TAX = 6'd47,
        OP_TAY = 6'd48, OP_TSX = 6'd49, OP_TXA = 6'd50, OP_TXS = 6'd51,
        OP_TYA = 6'd52
    } action_t;

    // stack pointer after reset
    localparam logic [7:0] STACK_START_RESET = 8'd253;

    // register index of stack_start, seen on paddr[2]
    localparam logic REG_STACK_START = 1'b0;

    typedef struct packed {
        logic n;
        logic v;
        logic d;
        logic i;
        logic z;
        logic c;
    } flags_t;

    typedef struct packed {
        action_t     action;
        logic        on_accumulator;
        logic [7:0]  operand;
        logic [15:0] target;
        logic [15:0] next_pc;
    } item_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        flags_t     flags;
    } cpu_state_t;

    typedef struct packed {
        logic [15:0] pc_out;
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [7:0]  acc_value;
        logic [7:0]  x_value;
        logic [7:0]  y_value;
        logic [7:0]  sp_value;
        logic [7:0]  status_value;
        logic        unhandled;
    } result_t;

    // up to two pushes per item; slot 1 is only used together with slot 0
    typedef struct packed {
        logic       en0;
        logic [7:0] addr0;
        logic [7:0] data0;
        logic       en1;
        logic [7:0] addr1;
        logic [7:0] data1;
    } stack_wr_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ceru_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ceru_stack
// Stack page, split into even and odd banks so that two consecutive entries
// can be written and read in one cycle. Registered read with write bypass,
// one valid bit per entry; an entry never written reads as zero.
// ----------------------------------------------------------------------------
module ceru_stack (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  ceru_pkg::stack_wr_t    wr,
    input  wire logic [7:0]        rd_base,
    output logic [7:0]             rd_lo,
    output logic [7:0]             rd_hi
);
    import ceru_pkg::*;

    logic [7:0]   mem_even [128];
    logic [7:0]   mem_odd  [128];
    logic [127:0] vld_even_reg;
    logic [127:0] vld_odd_reg;

    logic [7:0] addr_lo;
    logic [7:0] addr_hi;
    logic [6:0] ridx_even;
    logic [6:0] ridx_odd;

    logic       we_even;
    logic [6:0] wa_even;
    logic [7:0] wd_even;
    logic       we_odd;
    logic [6:0] wa_odd;
    logic [7:0] wd_odd;

    logic [7:0] data_even_reg;
    logic [7:0] data_odd_reg;
    logic       hit_even_reg;
    logic       hit_odd_reg;
    logic       lo_odd_reg;
    logic [7:0] out_even;
    logic [7:0] out_odd;

    // reads cover base+1 and base+2, one in each bank
    assign addr_lo   = rd_base + 8'd1;
    assign addr_hi   = rd_base + 8'd2;
    assign ridx_even = addr_lo[0] ? addr_hi[7:1] : addr_lo[7:1];
    assign ridx_odd  = addr_lo[0] ? addr_lo[7:1] : addr_hi[7:1];

    always_comb begin
        we_even = 1'b0;
        wa_even = wr.addr1[7:1];
        wd_even = wr.data1;
        we_odd  = 1'b0;
        wa_odd  = wr.addr1[7:1];
        wd_odd  = wr.data1;
        if (wr.en0 && !wr.addr0[0]) begin
            we_even = 1'b1;
            wa_even = wr.addr0[7:1];
            wd_even = wr.data0;
        end else if (wr.en1 && !wr.addr1[0]) begin
            we_even = 1'b1;
        end
        if (wr.en0 && wr.addr0[0]) begin
            we_odd = 1'b1;
            wa_odd = wr.addr0[7:1];
            wd_odd = wr.data0;
        end else if (wr.en1 && wr.addr1[0]) begin
            we_odd = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we_even) begin
            mem_even[wa_even] <= wd_even;
        end
        if (we_even && (wa_even == ridx_even)) begin
            data_even_reg <= wd_even;
        end else begin
            data_even_reg <= mem_even[ridx_even];
        end
        if (we_odd) begin
            mem_odd[wa_odd] <= wd_odd;
        end
        if (we_odd && (wa_odd == ridx_odd)) begin
            data_odd_reg <= wd_odd;
        end else begin
            data_odd_reg <= mem_odd[ridx_odd];
        end
        lo_odd_reg <= addr_lo[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_even_reg <= '0;
            vld_odd_reg  <= '0;
            hit_even_reg <= 1'b0;
            hit_odd_reg  <= 1'b0;
        end else begin
            if (we_even) begin
                vld_even_reg[wa_even] <= 1'b1;
            end
            if (we_odd) begin
                vld_odd_reg[wa_odd] <= 1'b1;
            end
            hit_even_reg <= vld_even_reg[ridx_even] || (we_even && (wa_even == ridx_even));
            hit_odd_reg  <= vld_odd_reg[ridx_odd] || (we_odd && (wa_odd == ridx_odd));
        end
    end

    assign out_even = hit_even_reg ? data_even_reg : 8'd0;
    assign out_odd  = hit_odd_reg ? data_odd_reg : 8'd0;
    assign rd_lo    = lo_odd_reg ? out_odd : out_even;
    assign rd_hi    = lo_odd_reg ? out_even : out_odd;

endmodule
`default_nettype wire

FILE: hw/rtl/ceru_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ceru_exec
// Instruction execute logic: next register and flag state, next PC, data
// write and stack pushes for one item, from the current state.
// ----------------------------------------------------------------------------
module ceru_exec (
    input  ceru_pkg::item_t        item,
    input  ceru_pkg::cpu_state_t   state,
    input  wire logic [7:0]        pull_lo,
    input  wire logic [7:0]        pull_hi,
    output ceru_pkg::cpu_state_t   state_next,
    output ceru_pkg::result_t      result,
    output ceru_pkg::stack_wr_t    stack_wr
);
    import ceru_pkg::*;

    function automatic logic [7:0] pack_status(flags_t f);
        return {f.n, f.v, 2'b11, f.d, f.i, f.z, f.c};
    endfunction

    logic [7:0]  add_m;
    logic [8:0]  sum;
    logic [7:0]  cmp_reg;
    logic [8:0]  diff;
    logic [7:0]  sh_src;
    logic [7:0]  sh_res;
    logic        sh_c;
    logic [15:0] ret_addr;

    cpu_state_t  ns;
    logic [15:0] pc;
    logic        we;
    logic [7:0]  wd;
    logic        bad;
    logic        upd_zn;
    logic [7:0]  zn_val;

    assign add_m    = (item.action == OP_SBC) ? ~item.operand : item.operand;
    assign sum      = {1'b0, state.acc} + {1'b0, add_m} + {8'd0, state.flags.c};
    assign diff     = {1'b0, cmp_reg} - {1'b0, item.operand};
    assign sh_src   = item.on_accumulator ? state.acc : item.operand;
    assign ret_addr = item.next_pc - 16'd1;

    always_comb begin
        case (item.action)
            OP_CPX:  cmp_reg = state.x;
            OP_CPY:  cmp_reg = state.y;
            default: cmp_reg = state.acc;
        endcase
    end

    always_comb begin
        case (item.action)
            OP_ASL: begin
                sh_res = {sh_src[6:0], 1'b0};
                sh_c   = sh_src[7];
            end
            OP_ROL: begin
                sh_res = {sh_src[6:0], state.flags.c};
                sh_c   = sh_src[7];
            end
            OP_ROR: begin
                sh_res = {state.flags.c, sh_src[7:1]};
                sh_c   = sh_src[0];
            end
            default: begin
                sh_res = {1'b0, sh_src[7:1]};
                sh_c   = sh_src[0];
            end
        endcase
    end

    always_comb begin
        ns       = state;
        pc       = item.next_pc;
        we       = 1'b0;
        wd       = 8'd0;
        bad      = 1'b0;
        upd_zn   = 1'b0;
        zn_val   = 8'd0;
        stack_wr = '0;
        stack_wr.addr0 = state.sp;
        stack_wr.addr1 = state.sp - 8'd1;

        case (item.action)
            OP_ADC, OP_SBC: begin
                ns.acc     = sum[7:0];
                ns.flags.c = sum[8];
                ns.flags.v = (state.acc[7] ^ sum[7]) & (add_m[7] ^ sum[7]);
                upd_zn     = 1'b1;
                zn_val     = sum[7:0];
            end
            OP_AND: begin
                ns.acc = state.acc & item.operand;
                upd_zn = 1'b1;
                zn_val = ns.acc;
            end
            OP_ORA: begin
                ns.acc = state.acc | item.operand;
                upd_zn = 1'b1;
                zn_val = ns.acc;
            end
            OP_EOR: begin
                ns.acc = state.acc ^ item.operand;
                upd_zn = 1'b1;
                zn_val = ns.acc;
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                ns.flags.c = sh_c;
                upd_zn     = 1'b1;
                zn_val     = sh_res;
                if (item.on_accumulator) begin
                    ns.acc = sh_res;
                end else begin
                    we = 1'b1;
                    wd = sh_res;
                end
            end
            OP_BCC: if (!state.flags.c) pc = item.target;
            OP_BCS: if (state.flags.c) pc = item.target;
            OP_BEQ: if (state.flags.z) pc = item.target;
            OP_BNE: if (!state.flags.z) pc = item.target;
            OP_BMI: if (state.flags.n) pc = item.target;
            OP_BPL: if (!state.flags.n) pc = item.target;
            OP_BVC: if (!state.flags.v) pc = item.target;
            OP_BVS: if (state.flags.v) pc = item.target;
            OP_BIT: begin
                ns.flags.z = ((state.acc & item.operand) == 8'd0);
                ns.flags.v = item.operand[6];
                ns.flags.n = item.operand[7];
            end
            OP_CLC: ns.flags.c = 1'b0;
            OP_CLD: ns.flags.d = 1'b0;
            OP_CLI: ns.flags.i = 1'b0;
            OP_CLV: ns.flags.v = 1'b0;
            OP_SEC: ns.flags.c = 1'b1;
            OP_SED: ns.flags.d = 1'b1;
            OP_SEI: ns.flags.i = 1'b1;
            OP_CMP, OP_CPX, OP_CPY: begin
                ns.flags.c = !diff[8];
                upd_zn     = 1'b1;
                zn_val     = diff[7:0];
            end
            OP_DEX: begin
                ns.x   = state.x - 8'd1;
                upd_zn = 1'b1;
                zn_val = ns.x;
            end
            OP_DEY: begin
                ns.y   = state.y - 8'd1;
                upd_zn = 1'b1;
                zn_val = ns.y;
            end
            OP_INX: begin
                ns.x   = state.x + 8'd1;
                upd_zn = 1'b1;
                zn_val = ns.x;
            end
            OP_INY: begin
                ns.y   = state.y + 8'd1;
                upd_zn = 1'b1;
                zn_val = ns.y;
            end
            OP_DEC: begin
                we     = 1'b1;
                wd     = item.operand - 8'd1;
                upd_zn = 1'b1;
                zn_val = wd;
            end
            OP_INC: begin
                we     = 1'b1;
                wd     = item.operand + 8'd1;
                upd_zn = 1'b1;
                zn_val = wd;
            end
            OP_JMP: pc = item.target;
            OP_JSR: begin
                // return address minus one, high byte first
                stack_wr.en0   = 1'b1;
                stack_wr.data0 = ret_addr[15:8];
                stack_wr.en1   = 1'b1;
                stack_wr.data1 = ret_addr[7:0];
                ns.sp          = state.sp - 8'd2;
                pc             = item.target;
            end
            OP_RTS: begin
                ns.sp = state.sp + 8'd2;
                pc    = {pull_hi, pull_lo} + 16'd1;
            end
            OP_LDA: begin
                ns.acc = item.operand;
                upd_zn = 1'b1;
                zn_val = item.operand;
            end
            OP_LDX: begin
                ns.x   = item.operand;
                upd_zn = 1'b1;
                zn_val = item.operand;
            end
            OP_LDY: begin
                ns.y   = item.operand;
                upd_zn = 1'b1;
                zn_val = item.operand;
            end
            OP_PHA: begin
                stack_wr.en0   = 1'b1;
                stack_wr.data0 = state.acc;
                ns.sp          = state.sp - 8'd1;
            end
            OP_PHP: begin
                stack_wr.en0   = 1'b1;
                stack_wr.data0 = pack_status(state.flags);
                ns.sp          = state.sp - 8'd1;
            end
            OP_PLA: begin
                ns.acc = pull_lo;
                ns.sp  = state.sp + 8'd1;
                upd_zn = 1'b1;
                zn_val = pull_lo;
            end
            OP_PLP: begin
                ns.sp      = state.sp + 8'd1;
                ns.flags.c = pull_lo[0];
                ns.flags.z = pull_lo[1];
                ns.flags.i = pull_lo[2];
                ns.flags.d = pull_lo[3];
                ns.flags.v = pull_lo[6];
                ns.flags.n = pull_lo[7];
            end
            OP_STA: begin
                we = 1'b1;
                wd = state.acc;
            end
            OP_STX: begin
                we = 1'b1;
                wd = state.x;
            end
            OP_STY: begin
                we = 1'b1;
                wd = state.y;
            end
            OP_TAX: begin
                ns.x   = state.acc;
                upd_zn = 1'b1;
                zn_val = state.acc;
            end
            OP_TAY: begin
                ns.y   = state.acc;
                upd_zn = 1'b1;
                zn_val = state.acc;
            end
            OP_TSX: begin
                ns.x   = state.sp;
                upd_zn = 1'b1;
                zn_val = state.sp;
            end
            OP_TXA: begin
                ns.acc = state.x;
                upd_zn = 1'b1;
                zn_val = state.x;
            end
            OP_TXS: ns.sp = state.x;
            OP_TYA: begin
                ns.acc = state.y;
                upd_zn = 1'b1;
                zn_val = state.y;
            end
            default: bad = 1'b1;
        endcase

        if (upd_zn) begin
            ns.flags.z = (zn_val == 8'd0);
            ns.flags.n = zn_val[7];
        end
    end

    assign state_next = ns;

    always_comb begin
        result.pc_out        = pc;
        result.write_enable  = we;
        result.write_address = we ? item.target : 16'd0;
        result.write_data    = wd;
        result.acc_value     = ns.acc;
        result.x_value       = ns.x;
        result.y_value       = ns.y;
        result.sp_value      = ns.sp;
        result.status_value  = pack_status(ns.flags);
        result.unhandled     = bad;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cpu_execute_register_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_execute_register_unit
// 6502 execute unit for pre-addressed instructions: A, X, Y, SP, flags and an
// internal stack page, one result item per instruction item.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake         Payload
//  s_       in   s_valid/s_ready   action, on_accumulator, operand, target, next_pc
//  m_       out  m_valid/m_ready   pc_out, write_*, acc/x/y/sp/status value, unhandled
//  apb      in   psel/penable      stack_start at address 0
//
//  One item per cycle sustained while results are taken; an item passes the input
//  register, then the result register. The execute logic between them sets the clock.
//  Stack page reads are registered from the next stack pointer every cycle.
//  Reset is synchronous; stack page valid bits all clear together, no sweep.
//  A held result stalls execution; one more item still enters the input reg.
// ----------------------------------------------------------------------------
module cpu_execute_register_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [5:0]  s_action,
    input  wire logic        s_on_accumulator,
    input  wire logic [7:0]  s_operand,
    input  wire logic [15:0] s_target,
    input  wire logic [15:0] s_next_pc,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_pc_out,
    output logic             m_write_enable,
    output logic [15:0]      m_write_address,
    output logic [7:0]       m_write_data,
    output logic [7:0]       m_acc_value,
    output logic [7:0]       m_x_value,
    output logic [7:0]       m_y_value,
    output logic [7:0]       m_sp_value,
    output logic [7:0]       m_status_value,
    output logic             m_unhandled,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ceru_pkg::*;

    logic        in_vld_reg;
    item_t       item_reg;
    logic        out_vld_reg;
    result_t     result_reg;
    cpu_state_t  state_reg;
    logic [7:0]  stack_start_reg;

    logic        exec;
    item_t       item_in;
    cpu_state_t  state_next;
    result_t     exec_result;
    stack_wr_t   stack_wr;
    logic [7:0]  pull_lo;
    logic [7:0]  pull_hi;
    logic [7:0]  rd_base;

    assign exec    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || exec;
    assign rd_base = exec ? state_next.sp : state_reg.sp;

    always_comb begin
        item_in.action         = action_t'(s_action);
        item_in.on_accumulator = s_on_accumulator;
        item_in.operand        = s_operand;
        item_in.target         = s_target;
        item_in.next_pc        = s_next_pc;
    end

    ceru_exec u_exec (
        .item       (item_reg),
        .state      (state_reg),
        .pull_lo    (pull_lo),
        .pull_hi    (pull_hi),
        .state_next (state_next),
        .result     (exec_result),
        .stack_wr   (stack_wr)
    );

    // pushes are gated by exec; the stack never sees stalled items
    stack_wr_t stack_wr_gated;
    always_comb begin
        stack_wr_gated     = stack_wr;
        stack_wr_gated.en0 = stack_wr.en0 && exec;
        stack_wr_gated.en1 = stack_wr.en1 && exec;
    end

    ceru_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (stack_wr_gated),
        .rd_base (rd_base),
        .rd_lo   (pull_lo),
        .rd_hi   (pull_hi)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            state_reg.acc   <= 8'd0;
            state_reg.x     <= 8'd0;
            state_reg.y     <= 8'd0;
            state_reg.sp    <= STACK_START_RESET;
            state_reg.flags <= '0;
            stack_start_reg <= STACK_START_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
                item_reg   <= item_in;
            end else if (exec) begin
                in_vld_reg <= 1'b0;
            end

            if (exec) begin
                out_vld_reg <= 1'b1;
                result_reg  <= exec_result;
                state_reg   <= state_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end

            // readback only; the pointer reloads its fixed reset value
            if (psel && penable && pwrite && (paddr[2] == REG_STACK_START)) begin
                stack_start_reg <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_STACK_START: prdata = {24'd0, stack_start_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign pready          = 1'b1;
    assign m_valid         = out_vld_reg;
    assign m_pc_out        = result_reg.pc_out;
    assign m_write_enable  = result_reg.write_enable;
    assign m_write_address = result_reg.write_address;
    assign m_write_data    = result_reg.write_data;
    assign m_acc_value     = result_reg.acc_value;
    assign m_x_value       = result_reg.x_value;
    assign m_y_value       = result_reg.y_value;
    assign m_sp_value      = result_reg.sp_value;
    assign m_status_value  = result_reg.status_value;
    assign m_unhandled     = result_reg.unhandled;

    a_unhandled_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && exec_result.unhandled |=> $stable(state_reg))
        else $error("unhandled item changed CPU state");

    a_jsr_pushes_two: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && (item_reg.action == OP_JSR) |=> state_reg.sp == $past(state_reg.sp) - 8'd2)
        else $error("JSR did not move SP by two");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> (m_write_address == 16'd0) && (m_write_data == 8'd0))
        else $error("write fields nonzero without write");

    a_sp_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> m_valid && (m_sp_value == state_reg.sp))
        else $error("result SP differs from held SP");

    a_empty_takes_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_ready)
        else $error("empty input register refused an item");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cpu_execute_register_unit. A scoreboard class keeps
// its own copy of A, X, Y, SP, flags and the stack page and predicts the
// result of each accepted instruction item. It compares every returned item
// field by field. Stimulus is a short directed list, a sweep of all action
// codes, and random instruction sequences (calls, pushes, compares and
// branches, arithmetic chains). Both channels get random gaps. The result
// side holds off for a long stretch once. stack_start is written and read
// back between phases.
// ----------------------------------------------------------------------------
module testbench;
    import ceru_pkg::*;

class cpu_register_scoreboard;
    logic [7:0]  acc, x, y, sp;
    flags_t      flags;
    logic [7:0]  stack_page [256];
    logic [7:0]  stack_start;
    result_t     expected_results [$];
    int unsigned error_count, instr_count, result_count;
    int unsigned unhandled_count, jump_count;

    function new();
        stack_start = STACK_START_RESET;
        acc   = '0;
        x     = '0;
        y     = '0;
        sp    = stack_start;
        flags = '0;
        foreach (stack_page[i]) stack_page[i] = '0;
    endfunction

    task report_mismatch(string msg);
        error_count++;
        $display("ERROR: %s", msg);
    endtask

    function int unsigned pending();
        return expected_results.size();
    endfunction

    function logic [7:0] status_byte();
        return {flags.n, flags.v, 2'b11, flags.d, flags.i, flags.z, flags.c};
    endfunction

    function void set_nz(logic [7:0] v);
        flags.z = (v == 8'd0);
        flags.n = v[7];
    endfunction

    function void push(logic [7:0] v);
        stack_page[sp] = v;
        sp = sp - 8'd1;
    endfunction

    function logic [7:0] pull();
        sp = sp + 8'd1;
        return stack_page[sp];
    endfunction

    function void compare(logic [7:0] r, logic [7:0] m);
        logic [7:0] diff;
        diff    = r - m;
        flags.c = (r >= m);
        set_nz(diff);
    endfunction

    function void add_with_carry(logic [7:0] m);
        logic [8:0] sum;
        logic [7:0] r;
        sum     = {1'b0, acc} + {1'b0, m} + {8'd0, flags.c};
        r       = sum[7:0];
        flags.c = sum[8];
        flags.v = ((acc ^ r) & (m ^ r) & 8'h80) != 8'd0;
        acc     = r;
        set_nz(r);
    endfunction

    // predict the result of one accepted instruction item
    function void note_instruction(item_t it);
        logic [7:0]  m, v, r;
        logic [15:0] ret;
        logic        jump;
        result_t     want;
        want        = '0;
        want.pc_out = it.next_pc;
        m           = it.operand;
        jump        = 1'b0;
        instr_count++;
        case (it.action)
            OP_ADC: add_with_carry(m);
            OP_SBC: add_with_carry(~m);
            OP_AND: begin acc = acc & m; set_nz(acc); end
            OP_ORA: begin acc = acc | m; set_nz(acc); end
            OP_EOR: begin acc = acc ^ m; set_nz(acc); end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                v = it.on_accumulator ? acc : m;
                case (it.action)
                    OP_ASL: begin r = {v[6:0], 1'b0};    flags.c = v[7]; end
                    OP_ROL: begin r = {v[6:0], flags.c}; flags.c = v[7]; end
                    OP_LSR: begin r = {1'b0, v[7:1]};    flags.c = v[0]; end
                    default: begin r = {flags.c, v[7:1]}; flags.c = v[0]; end
                endcase
                set_nz(r);
                if (it.on_accumulator) begin
                    acc = r;
                end else begin
                    want.write_enable = 1'b1;
                    want.write_data   = r;
                end
            end
            OP_BCC: jump = !flags.c;
            OP_BCS: jump = flags.c;
            OP_BEQ: jump = flags.z;
            OP_BNE: jump = !flags.z;
            OP_BMI: jump = flags.n;
            OP_BPL: jump = !flags.n;
            OP_BVC: jump = !flags.v;
            OP_BVS: jump = flags.v;
            OP_BIT: begin
                flags.z = (acc & m) == 8'd0;
                flags.v = m[6];
                flags.n = m[7];
            end
            OP_CLC: flags.c = 1'b0;
            OP_CLD: flags.d = 1'b0;
            OP_CLI: flags.i = 1'b0;
            OP_CLV: flags.v = 1'b0;
            OP_SEC: flags.c = 1'b1;
            OP_SED: flags.d = 1'b1;
            OP_SEI: flags.i = 1'b1;
            OP_CMP: compare(acc, m);
            OP_CPX: compare(x, m);
            OP_CPY: compare(y, m);
            OP_DEX: begin x = x - 8'd1; set_nz(x); end
            OP_DEY: begin y = y - 8'd1; set_nz(y); end
            OP_INX: begin x = x + 8'd1; set_nz(x); end
            OP_INY: begin y = y + 8'd1; set_nz(y); end
            OP_DEC: begin
                want.write_enable = 1'b1;
                want.write_data   = m - 8'd1;
                set_nz(want.write_data);
            end
            OP_INC: begin
                want.write_enable = 1'b1;
                want.write_data   = m + 8'd1;
                set_nz(want.write_data);
            end
            OP_JMP: jump = 1'b1;
            OP_JSR: begin
                // return address is the last byte of the call
                ret = it.next_pc - 16'd1;
                push(ret[15:8]);
                push(ret[7:0]);
                jump = 1'b1;
            end
            OP_RTS: begin
                v = pull();
                r = pull();
                want.pc_out = {r, v} + 16'd1;
            end
            OP_LDA: begin acc = m; set_nz(acc); end
            OP_LDX: begin x = m; set_nz(x); end
            OP_LDY: begin y = m; set_nz(y); end
            OP_PHA: push(acc);
            OP_PHP: push(status_byte());
            OP_PLA: begin acc = pull(); set_nz(acc); end
            OP_PLP: begin
                v     = pull();
                flags = {v[7:6], v[3:0]};
            end
            OP_STA: begin want.write_enable = 1'b1; want.write_data = acc; end
            OP_STX: begin want.write_enable = 1'b1; want.write_data = x; end
            OP_STY: begin want.write_enable = 1'b1; want.write_data = y; end
            OP_TAX: begin x = acc; set_nz(x); end
            OP_TAY: begin y = acc; set_nz(y); end
            OP_TSX: begin x = sp; set_nz(x); end
            OP_TXA: begin acc = x; set_nz(acc); end
            OP_TXS: sp = x;
            OP_TYA: begin acc = y; set_nz(acc); end
            default: begin
                want.unhandled = 1'b1;
                unhandled_count++;
            end
        endcase
        if (jump) begin
            want.pc_out = it.target;
            jump_count++;
        end
        if (want.write_enable)
            want.write_address = it.target;
        want.acc_value    = acc;
        want.x_value      = x;
        want.y_value      = y;
        want.sp_value     = sp;
        want.status_value = status_byte();
        expected_results.push_back(want);
    endfunction

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %h, expected %h",
                                      result_count, name, got, want));
    endtask

    task check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result item with no instruction pending: %h", got));
            return;
        end
        want = expected_results.pop_front();
        compare_field("pc_out",        got.pc_out,             want.pc_out);
        compare_field("write_enable",  16'(got.write_enable),  16'(want.write_enable));
        compare_field("write_address", got.write_address,      want.write_address);
        compare_field("write_data",    16'(got.write_data),    16'(want.write_data));
        compare_field("acc_value",     16'(got.acc_value),     16'(want.acc_value));
        compare_field("x_value",       16'(got.x_value),       16'(want.x_value));
        compare_field("y_value",       16'(got.y_value),       16'(want.y_value));
        compare_field("sp_value",      16'(got.sp_value),      16'(want.sp_value));
        compare_field("status_value",  16'(got.status_value),  16'(want.status_value));
        compare_field("unhandled",     16'(got.unhandled),     16'(want.unhandled));
        result_count++;
    endtask
endclass

    localparam int          CYCLE_LIMIT      = 400000;
    localparam int          HOLD_OFF_CYCLES  = 120;
    localparam int          DRAIN_CYCLES     = 4;
    localparam logic [2:0]  STACK_START_ADDR = {REG_STACK_START, 2'b00};
    localparam logic [5:0]  ACTION_UNKNOWN_FIRST = 6'd53;
    localparam logic [5:0]  ACTION_UNKNOWN_LAST  = 6'd63;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [5:0]  s_action         = '0;
    logic        s_on_accumulator = 1'b0;
    logic [7:0]  s_operand        = '0;
    logic [15:0] s_target         = '0;
    logic [15:0] s_next_pc        = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [15:0] m_pc_out;
    logic        m_write_enable;
    logic [15:0] m_write_address;
    logic [7:0]  m_write_data;
    logic [7:0]  m_acc_value;
    logic [7:0]  m_x_value;
    logic [7:0]  m_y_value;
    logic [7:0]  m_sp_value;
    logic [7:0]  m_status_value;
    logic        m_unhandled;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [2:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;

    cpu_register_scoreboard sb;
    int unsigned cycle_count     = 0;
    int unsigned sent_count      = 0;
    int unsigned config_count    = 0;
    bit          no_idling       = 1'b0;
    bit          hold_off_request = 1'b0;
    bit          hold_off_active  = 1'b0;

    cpu_execute_register_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_on_accumulator (s_on_accumulator),
        .s_operand        (s_operand),
        .s_target         (s_target),
        .s_next_pc        (s_next_pc),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pc_out         (m_pc_out),
        .m_write_enable   (m_write_enable),
        .m_write_address  (m_write_address),
        .m_write_data     (m_write_data),
        .m_acc_value      (m_acc_value),
        .m_x_value        (m_x_value),
        .m_y_value        (m_y_value),
        .m_sp_value       (m_sp_value),
        .m_status_value   (m_status_value),
        .m_unhandled      (m_unhandled),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("testbench failed");
            $finish;
        end
    end

    // monitors: values seen here are the ones present at the edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_instruction({s_action, s_on_accumulator, s_operand, s_target, s_next_pc});
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_pc_out, m_write_enable, m_write_address, m_write_data,
                             m_acc_value, m_x_value, m_y_value, m_sp_value,
                             m_status_value, m_unhandled});
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_off_active  = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_active  = 1'b0;
            end else begin
                stall = no_idling ? 0 : pick_gap();
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    task automatic send_instruction(input logic [5:0] action, input logic on_acc,
                                    input logic [7:0] operand, input logic [15:0] target,
                                    input logic [15:0] next_pc);
        int unsigned gap;
        gap = (no_idling || hold_off_active) ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_action         <= action;
        s_on_accumulator <= on_acc;
        s_operand        <= operand;
        s_target         <= target;
        s_next_pc        <= next_pc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic issue(input logic [5:0] action);
        send_instruction(action, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    function automatic logic [5:0] random_action();
        if ($urandom_range(0, 15) == 0)
            return 6'($urandom_range(ACTION_UNKNOWN_FIRST, ACTION_UNKNOWN_LAST));
        return 6'($urandom_range(0, OP_TYA));
    endfunction

    // ops that leave the stack alone
    function automatic action_t pick_data_op();
        case ($urandom_range(0, 15))
            0:  return OP_ADC;
            1:  return OP_SBC;
            2:  return OP_AND;
            3:  return OP_ORA;
            4:  return OP_EOR;
            5:  return OP_LDA;
            6:  return OP_LDX;
            7:  return OP_LDY;
            8:  return OP_INX;
            9:  return OP_DEY;
            10: return OP_TAX;
            11: return OP_TYA;
            12: return OP_INC;
            13: return OP_STA;
            14: return OP_SEC;
            default: return OP_CLV;
        endcase
    endfunction

    function automatic action_t pick_branch_op();
        case ($urandom_range(0, 7))
            0: return OP_BCC;
            1: return OP_BCS;
            2: return OP_BEQ;
            3: return OP_BNE;
            4: return OP_BMI;
            5: return OP_BPL;
            6: return OP_BVC;
            default: return OP_BVS;
        endcase
    endfunction

    // one random instruction or one short well-formed sequence
    task automatic random_sequence();
        int unsigned n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: issue(random_action());
            4: begin
                issue(OP_JSR);
                repeat ($urandom_range(0, 3)) issue(pick_data_op());
                issue(OP_RTS);
            end
            5: begin
                issue($urandom_range(0, 1) ? OP_PHA : OP_PHP);
                repeat ($urandom_range(0, 2)) issue(pick_data_op());
                issue($urandom_range(0, 1) ? OP_PLA : OP_PLP);
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: issue(OP_CMP);
                    1: issue(OP_CPX);
                    2: issue(OP_CPY);
                    default: issue(OP_BIT);
                endcase
                issue(pick_branch_op());
            end
            7: begin
                issue($urandom_range(0, 1) ? OP_SEC : OP_CLC);
                n = $urandom_range(1, 4);
                repeat (n) issue($urandom_range(0, 1) ? OP_ADC : OP_SBC);
                issue(pick_branch_op());
            end
            8: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: issue(OP_ASL);
                        1: issue(OP_LSR);
                        2: issue(OP_ROL);
                        default: issue(OP_ROR);
                    endcase
                end
                issue(OP_STA);
            end
            default: begin
                // move the stack pointer somewhere random, then use it
                issue(OP_LDX);
                issue(OP_TXS);
                issue($urandom_range(0, 1) ? OP_PHA : OP_PHP);
                issue($urandom_range(0, 1) ? OP_PLA : OP_PLP);
                issue(OP_TSX);
            end
        endcase
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (got !== want)
            sb.report_mismatch($sformatf("register read at %h gave %h, expected %h",
                                         addr, got, want));
    endtask

    task automatic set_stack_start(input logic [7:0] value);
        apb_write(STACK_START_ADDR, {24'd0, value});
        sb.stack_start = value;   // readback only; SP is never loaded from it
        config_count++;
        apb_check(STACK_START_ADDR, {24'd0, value});
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int          order [64];
        int          j, t;
        logic [7:0]  cfg;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_check(STACK_START_ADDR, {24'd0, STACK_START_RESET});

        // directed: field extremes and the corner cases
        send_instruction(OP_LDA, 1'b1, 8'hFF, 16'hFFFF, 16'h0001); // acc flag ignored
        send_instruction(OP_ADC, 1'b0, 8'h01, 16'h0000, 16'h0002); // wraps to zero
        send_instruction(OP_ADC, 1'b0, 8'h7F, 16'h0000, 16'h0004); // signed overflow
        send_instruction(OP_ASL, 1'b1, 8'h00, 16'h0000, 16'h0005);
        send_instruction(OP_ROR, 1'b0, 8'h01, 16'hFFFF, 16'h0007);
        send_instruction(OP_LSR, 1'b0, 8'hFF, 16'h0000, 16'h0009);
        send_instruction(OP_INC, 1'b0, 8'hFF, 16'h8000, 16'h000B);
        send_instruction(OP_DEC, 1'b0, 8'h00, 16'h7FFF, 16'h000D);
        send_instruction(OP_BIT, 1'b0, 8'hC0, 16'h0000, 16'h000F);
        send_instruction(OP_BMI, 1'b0, 8'h00, 16'hFFFF, 16'h0000); // taken
        send_instruction(OP_BPL, 1'b0, 8'hFF, 16'h1234, 16'hFFFF); // not taken
        send_instruction(OP_JSR, 1'b0, 8'h00, 16'h1234, 16'h0000); // return address wraps
        send_instruction(OP_RTS, 1'b0, 8'h00, 16'h0000, 16'h1236);
        send_instruction(OP_PHP, 1'b0, 8'h00, 16'h0000, 16'h0010);
        send_instruction(OP_PLA, 1'b0, 8'h00, 16'h0000, 16'h0011);
        send_instruction(OP_LDA, 1'b0, 8'h00, 16'h0000, 16'h0013);
        send_instruction(OP_PHA, 1'b0, 8'h00, 16'h0000, 16'h0014);
        send_instruction(OP_PLP, 1'b0, 8'h00, 16'h0000, 16'h0015); // clears all flags
        send_instruction(OP_LDA, 1'b0, 8'hFF, 16'h0000, 16'h0017);
        send_instruction(OP_PHA, 1'b0, 8'h00, 16'h0000, 16'h0018);
        send_instruction(OP_PLP, 1'b0, 8'h00, 16'h0000, 16'h0019); // B and U ignored
        send_instruction(OP_LDX, 1'b0, 8'h00, 16'h0000, 16'h001B);
        send_instruction(OP_TXS, 1'b0, 8'h00, 16'h0000, 16'h001C);
        send_instruction(OP_PHA, 1'b0, 8'h00, 16'h0000, 16'h001D); // SP wraps to FF
        send_instruction(OP_TSX, 1'b0, 8'h00, 16'h0000, 16'h001E);
        send_instruction(ACTION_UNKNOWN_LAST, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_instruction(ACTION_UNKNOWN_FIRST, 1'b0, 8'h00, 16'h0000, 16'h0000);
        wait_idle();

        for (int phase = 0; phase < 3; phase++) begin
            cfg = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom_range(1, 254));
            set_stack_start(cfg);
            no_idling = (phase == 1);
            if (phase == 0) begin
                hold_off_request = 1'b1;
                // every action code once, in shuffled order
                for (int i = 0; i < 64; i++) order[i] = i;
                for (int i = 63; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                for (int i = 0; i < 64; i++) issue(6'(order[i]));
            end
            while (sent_count < 225 + 200 * phase) random_sequence();
            wait_idle();
        end
        no_idling = 1'b0;

        $display("ran %0d instructions: %0d unhandled, %0d jumps or taken branches",
                 sb.instr_count, sb.unhandled_count, sb.jump_count);
        $display("checked %0d result items across %0d stack_start settings, %0d mismatches",
                 sb.result_count, config_count, sb.error_count);
        if (sb.error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ceru_pkg.sv
hw/rtl/ceru_stack.sv
hw/rtl/ceru_exec.sv
hw/rtl/cpu_execute_register_unit.sv
tb/testbench.sv
